// ----- src/wpta_pkg.sv -----
// Package: sizes, types and LRU helpers for the way-predicted tag array.
`default_nettype none
package wpta_pkg;
  localparam int NumSets        = 64;
  localparam int NumWays        = 8;
  localparam int LineOffsetBits = 6;
  localparam int SetBits        = (NumSets > 1) ? $clog2(NumSets) : 1;
  localparam int WayBits        = 3;
  localparam int TagBits        = 20;
  localparam int TagShift       = 12;
  localparam int LruBits        = NumWays * NumWays;
  localparam int InDataBits     = 72;
  localparam int OutDataBits    = 8;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_FILL   = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [TagBits-1:0]   tag;
    logic [SetBits-1:0]   set;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [WayBits-1:0] way;
  } rsp_t;

  function automatic logic [LruBits-1:0] lru_touch(input logic [LruBits-1:0] m,
                                                   input logic [WayBits-1:0] w);
    logic [LruBits-1:0] r;
    r = m;
    for (int i = 0; i < NumWays; i++) begin
      if (w == WayBits'(i)) begin
        for (int c = 0; c < NumWays; c++) r[i*NumWays+c] = 1'b1;
      end
    end
    for (int i = 0; i < NumWays; i++) begin
      for (int c = 0; c < NumWays; c++) begin
        if (w == WayBits'(c)) r[i*NumWays+c] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [WayBits-1:0] lru_victim(input logic [LruBits-1:0] m);
    logic [WayBits-1:0] v;
    logic               f;
    v = '0;
    f = 1'b0;
    for (int i = 0; i < NumWays; i++) begin
      if (!f && m[i*NumWays +: NumWays] == '0) begin
        v = WayBits'(i);
        f = 1'b1;
      end
    end
    return v;
  endfunction
endpackage
`default_nettype wire

// ----- src/wpta_front.sv -----
// Front end: accept input words, decode set and tag, queue requests.
`default_nettype none
module wpta_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [wpta_pkg::InDataBits-1:0] in_tdata,
  output logic                               req_valid,
  input  wire logic                          req_ready,
  output wpta_pkg::req_t                     req
);
  import wpta_pkg::*;

  req_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wp_nxt, rp_nxt;
  logic [1:0] cnt_nxt;
  req_t       dec;
  logic       push, pop;

  always_comb begin
    dec.cmd = cmd_t'(in_tdata[0]);
    dec.tag = in_tdata[1+TagShift +: TagBits];
    dec.set = SetBits'(in_tdata[33+LineOffsetBits +: 26] % NumSets);
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign req_valid = (cnt_r != 2'd0);
  assign pop       = req_valid && req_ready;
  assign req       = q_r[rp_r];
  assign wp_nxt    = push ? ~wp_r : wp_r;
  assign rp_nxt    = pop ? ~rp_r : rp_r;
  assign cnt_nxt   = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= dec;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- src/wpta_back.sv -----
// Back end: read set state, resolve lookup or fill, update, emit result.
`default_nettype none
module wpta_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          req_valid,
  output logic                               req_ready,
  input  wire wpta_pkg::req_t                req,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [wpta_pkg::OutDataBits-1:0]   out_tdata
);
  import wpta_pkg::*;

  typedef enum logic [3:0] {
    ST_CLR  = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic [NumWays-1:0] vld;
    logic [WayBits-1:0] pred;
    logic [LruBits-1:0] lru;
  } set_st_t;

  state_t                 state_r, state_nxt;
  logic [SetBits-1:0]     clr_r, clr_nxt;
  logic [TagBits-1:0]     tag_mem [NumSets][NumWays];
  set_st_t                set_mem [NumSets];
  set_st_t                set_rd_r;
  set_st_t                set_wr;
  req_t                   cur_r;
  logic [TagBits-1:0]     rtag_r [NumWays];
  rsp_t                   rsp_r, rsp_nxt;
  logic [NumWays-1:0]     vset;
  logic [WayBits-1:0]     pred;
  logic [LruBits-1:0]     lru;
  logic [NumWays-1:0]     match;
  logic                   upd, first_inv_f;
  logic [WayBits-1:0]     first_inv;

  assign vset = set_rd_r.vld;
  assign pred = set_rd_r.pred;
  assign lru  = set_rd_r.lru;

  always_comb begin
    for (int i = 0; i < NumWays; i++) match[i] = vset[i] && (rtag_r[i] == cur_r.tag);
    first_inv_f = 1'b0;
    first_inv   = '0;
    for (int i = 0; i < NumWays; i++) begin
      if (!first_inv_f && !vset[i]) begin
        first_inv   = WayBits'(i);
        first_inv_f = 1'b1;
      end
    end
    rsp_nxt = '0;
    upd     = 1'b0;
    if (cur_r.cmd == CMD_FILL) begin
      rsp_nxt.hit = 1'b1;
      rsp_nxt.way = first_inv_f ? first_inv : lru_victim(lru);
      upd         = 1'b1;
    end else if (32'(pred) < NumWays && match[pred]) begin
      rsp_nxt.hit = 1'b1;
      rsp_nxt.way = pred;
      upd         = 1'b1;
    end else begin
      for (int i = NumWays-1; i >= 0; i--) begin
        if (match[i] && WayBits'(i) != pred) begin
          rsp_nxt.hit = 1'b1;
          rsp_nxt.way = WayBits'(i);
          upd         = 1'b1;
        end
      end
    end
  end

  always_comb begin
    set_wr.lru  = lru_touch(lru, rsp_nxt.way);
    set_wr.pred = rsp_nxt.way;
    set_wr.vld  = vset;
    if (cur_r.cmd == CMD_FILL) set_wr.vld[rsp_nxt.way] = 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  if (clr_r == SetBits'(NumSets-1)) state_nxt = ST_IDLE;
      ST_IDLE: if (req_valid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_OUT;
      ST_OUT:  if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLR;
    endcase
  end

  assign clr_nxt    = (state_r == ST_CLR) ? clr_r + SetBits'(1) : clr_r;
  assign req_ready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = OutDataBits'({rsp_r.way, rsp_r.hit});

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && req_valid) begin
      cur_r    <= req;
      set_rd_r <= set_mem[req.set];
      for (int i = 0; i < NumWays; i++) rtag_r[i] <= tag_mem[req.set][i];
    end
    if (state_r == ST_EXEC) begin
      rsp_r <= rsp_nxt;
      if (cur_r.cmd == CMD_FILL) tag_mem[cur_r.set][rsp_nxt.way] <= cur_r.tag;
    end
    if (state_r == ST_CLR) begin
      set_mem[clr_r] <= '0;
    end else if (state_r == ST_EXEC && upd) begin
      set_mem[cur_r.set] <= set_wr;
    end
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- src/way_predicted_set_assoc_tag_array_core.sv -----
// Top level: way-predicted set-associative tag array.
// Each accepted word passes the front queue, then the back end's read/resolve/output
// sequence; the back end takes a new word only once the last result word is taken.
// A two-entry queue lets the front accept words while the back end works.
// Reset: synchronous active-low; a pass over all sets (one set per cycle) then clears
// valid bits, predictions and LRU state, and the back end takes no word until it ends.
`default_nettype none
module way_predicted_set_assoc_tag_array_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // command[0], virt_addr[32:1], phys_addr[64:33]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // hit[0], way_index[3:1]
);
  import wpta_pkg::*;

  logic req_valid, req_ready;
  req_t req;

  wpta_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .req_valid(req_valid), .req_ready(req_ready), .req(req)
  );

  wpta_back u_back (
    .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
    .req(req), .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out hold");
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[3:1] == 3'd0) else $error("miss way");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:4] == 4'd0) else $error("pad");
endmodule
`default_nettype wire

// ----- sim/tb_way_predicted_set_assoc_tag_array_core.sv -----
// Testbench: random and directed lookups and fills checked against a tag array predictor.
`default_nettype none
module tb_way_predicted_set_assoc_tag_array_core;
  import wpta_pkg::*;

  class tag_scoreboard;
    bit          valid_q [NumSets][NumWays];
    logic [19:0] tag_q   [NumSets][NumWays];
    logic [2:0]  pred_q  [NumSets];
    logic [63:0] lru_q   [NumSets];
    logic [3:0]  pending [$];
    int          errors;
    int          checked;

    function new();
      for (int s = 0; s < NumSets; s++) begin
        pred_q[s] = '0;
        lru_q[s] = '0;
        for (int w = 0; w < NumWays; w++) begin
          valid_q[s][w] = 0;
          tag_q[s][w] = '0;
        end
      end
    endfunction

    function void touch(int s, int w);
      for (int c = 0; c < NumWays; c++) lru_q[s][8*w+c] = 1'b1;
      for (int r = 0; r < NumWays; r++) lru_q[s][8*r+w] = 1'b0;
    endfunction

    function void note_word(cmd_t cmd, logic [31:0] va, logic [31:0] pa);
      int s, w, p;
      logic [19:0] tg;
      bit found;
      s = (pa >> LineOffsetBits) % NumSets;
      tg = va[31:12];
      found = 0;
      w = 0;
      if (cmd == CMD_LOOKUP) begin
        p = pred_q[s];
        if (p < NumWays && valid_q[s][p] && tag_q[s][p] == tg) begin
          touch(s, p);
          pending.push_back({3'(p), 1'b1});
          return;
        end
        for (int i = 0; i < NumWays; i++) begin
          if (!found && i != p && valid_q[s][i] && tag_q[s][i] == tg) begin
            found = 1;
            w = i;
          end
        end
        if (found) begin
          pred_q[s] = 3'(w);
          touch(s, w);
          pending.push_back({3'(w), 1'b1});
        end else begin
          pending.push_back(4'b0);
        end
      end else begin
        w = NumWays;
        for (int i = NumWays - 1; i >= 0; i--) if (!valid_q[s][i]) w = i;
        if (w >= NumWays) begin
          w = 0;
          found = 0;
          for (int r = 0; r < NumWays; r++) begin
            if (!found && lru_q[s][8*r +: 8] == 8'h00) begin
              w = r;
              found = 1;
            end
          end
        end
        tag_q[s][w] = tg;
        valid_q[s][w] = 1;
        touch(s, w);
        pred_q[s] = 3'(w);
        pending.push_back({3'(w), 1'b1});
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_word(logic [7:0] d);
      logic [3:0] e;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result word %h", d));
        return;
      end
      e = pending.pop_front();
      if (d[0] !== e[0]) report($sformatf("hit got %b want %b", d[0], e[0]));
      if (d[3:1] !== e[3:1]) report($sformatf("way got %0d want %0d", d[3:1], e[3:1]));
      if (d[7:4] !== 4'b0) report($sformatf("pad bits got %h", d[7:4]));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  tag_scoreboard sb;
  int          idle_cycles;
  int          sent;
  bit          stim_done;
  logic [19:0] tag_pool [8];

  way_predicted_set_assoc_tag_array_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(cmd_t cmd, logic [31:0] va, logic [31:0] pa);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, pa, va, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(cmd, va, pa);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] make_va(logic [19:0] tg);
    return {tg, 12'($urandom)};
  endfunction

  function automatic logic [31:0] make_pa(int s);
    logic [31:0] r;
    r = $urandom;
    r[11:6] = 6'(s);
    return r;
  endfunction

  initial begin : out_side
    int g;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      g = gap_len();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_word(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stim
    int s;
    logic [31:0] v;
    sb = new();
    idle_cycles = 0;
    sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, miss on empty, fill a set fully, evict, hit in and out of prediction
    send_word(CMD_LOOKUP, 32'h0, 32'h0);
    send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_FILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_LOOKUP, 32'hFFFF_F000, 32'h0000_0FC0);
    for (int w = 0; w < 9; w++) send_word(CMD_FILL, {20'(w + 1), 12'h0}, 32'h40);
    send_word(CMD_LOOKUP, {20'd3, 12'hABC}, 32'h40);
    send_word(CMD_LOOKUP, {20'd9, 12'h0}, 32'h40);
    send_word(CMD_LOOKUP, {20'd5, 12'h0}, 32'hFFFF_F07F);
    send_word(CMD_FILL, {20'd77, 12'h0}, 32'h40);
    send_word(CMD_LOOKUP, {20'd77, 12'h0}, 32'h40);
    send_word(CMD_LOOKUP, 32'h0, 32'h0);
    send_word(CMD_FILL, 32'h0, 32'h0);
    send_word(CMD_LOOKUP, 32'h0000_0FFF, 32'h0000_003F);

    // random: small tag pool over few sets so hits, evictions and prediction moves are common
    for (int i = 0; i < 8; i++) tag_pool[i] = 20'($urandom);
    for (int i = 0; i < 1200; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(cmd_t'($urandom_range(0, 1)), $urandom, $urandom);
      end else begin
        s = $urandom_range(0, 3) == 0 ? $urandom_range(0, NumSets - 1)
                                      : $urandom_range(0, 3);
        v = make_va(tag_pool[$urandom_range(0, 7)]);
        if ($urandom_range(0, 19) == 0) v[31:12] = 20'($urandom);
        send_word(cmd_t'($urandom_range(0, 99) < 35), v, make_pa(s));
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d words, checked %0d results over lookups and fills", sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
